// File: rtl/rdq_pkg.sv
// Package for the reversible deque: sizes, command and status codes, state and cell control types.
package rdq_pkg;

    localparam int DEPTH   = 1024;
    localparam int WORD_W  = 32;
    localparam int GROUP   = 32;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int IN_W    = ((CMD_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_W   = ((STAT_W + WORD_W + 7) / 8) * 8;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_REVERSE    = 3'd3,
        CMD_PUSH_BACK  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_GATHER
    } t_state;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic  shift_r;    // push at cell 0, everything moves one cell up
        logic  shift_l;    // pop at cell 0, everything moves one cell down
        logic  put_back;   // first free cell takes the value
        logic  take_back;  // last used cell is released
        t_word value;
    } t_cell_ctl;

endpackage

// File: rtl/rdq_cell.sv
// One storage cell of the deque chain: a word and its occupancy bit.
module rdq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdq_pkg::t_cell_ctl i_ctl,
    input  rdq_pkg::t_word    i_left_data,
    input  logic              i_left_used,
    input  rdq_pkg::t_word    i_right_data,
    input  logic              i_right_used,
    output rdq_pkg::t_word    o_data,
    output logic              o_used,
    output logic              o_last
);
    import rdq_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_used;
    logic  n_used;

    always_comb begin
        n_data = r_data;
        n_used = r_used;
        if (i_ctl.shift_r) begin
            n_data = i_left_data;
            n_used = i_left_used;
        end else if (i_ctl.shift_l) begin
            n_data = i_right_data;
            n_used = i_right_used;
        end else if (i_ctl.put_back && !r_used && i_left_used) begin
            n_data = i_ctl.value;
            n_used = 1'b1;
        end else if (i_ctl.take_back && r_used && !i_right_used) begin
            n_used = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_used = r_used;
    assign o_last = r_used && !i_right_used;

endmodule

// File: rtl/rdq_gather.sv
// Two-level OR tree that picks out the word of the last used cell.
module rdq_gather (
    input  logic                                       i_clk,
    input  logic                                       i_load,
    input  logic [rdq_pkg::DEPTH-1:0][rdq_pkg::WORD_W-1:0] i_data,
    input  logic [rdq_pkg::DEPTH-1:0]                  i_last,
    output rdq_pkg::t_word                             o_word
);
    import rdq_pkg::*;

    logic [NGROUPS-1:0][WORD_W-1:0] w_grp;
    logic [NGROUPS-1:0][WORD_W-1:0] r_grp;
    logic [WORD_W-1:0]              w_any;

    // Exactly one cell is flagged last, so OR picks its word.
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    w_grp[g] = w_grp[g] |
                               (i_data[g * GROUP + k] & {WORD_W{i_last[g * GROUP + k]}});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= w_grp;
        end
    end

    always_comb begin
        w_any = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            w_any = w_any | r_grp[g];
        end
    end

    assign o_word = t_word'(w_any);

endmodule

// File: rtl/reversible_deque_top.sv
// Top level of the reversible deque: cell chain, back-word gather, result buffering.
//
// A bounded double-ended queue of up to DEPTH (1024) signed 32-bit words kept in a
// chain of cells: cell 0 is the physical front and used cells always form a
// contiguous run from it. Pushing or popping at the physical front shifts the
// whole chain one cell; at the physical back the first free or last used cell
// acts locally. The reverse command flips a flag that swaps which physical end is
// the logical front, so it costs nothing. Input word: command [2:0], push_value
// [34:3]. Result word: status [1:0] (0 ok, 1 empty on pop, 2 full, push dropped),
// popped_value [33:2], zero unless status is ok. Pushes that fit and reverses give
// no result; codes five to seven are ignored. Throughput is one command per cycle,
// except that a pop at the physical back stalls input while the word of the
// last used cell is collected through a registered 32-way OR tree over the chain.
// Results sit in an output register backed by one skid register; input is
// stalled only while reset is held, while both hold words or while a back pop
// is being collected.
module reversible_deque_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [rdq_pkg::IN_W-1:0]   i_s_tdata,   // command[2:0], push_value[34:3]
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [rdq_pkg::OUT_W-1:0]  o_m_tdata    // status[1:0], popped_value[33:2]
);
    import rdq_pkg::*;

    // chain wiring
    logic [DEPTH-1:0][WORD_W-1:0] w_data;
    logic [DEPTH-1:0]             w_used;
    logic [DEPTH-1:0]             w_last;
    t_cell_ctl                    w_ctl;
    t_word                        w_gather;

    // control
    t_state  r_state;
    t_state  n_state;
    logic    r_rev;
    logic    w_accept;
    logic    w_ready;
    logic    w_gather_done;
    logic    w_is_push;
    logic    w_is_pop;
    logic    w_front;
    logic    w_full;
    logic    w_empty;
    logic    w_take_back;

    // result buffering
    logic    w_res_push;
    t_status w_res_status;
    t_word   w_res_word;
    logic    r_out_valid;
    t_status r_out_status;
    t_word   r_out_word;
    logic    r_skid_valid;
    t_status r_skid_status;
    t_word   r_skid_word;
    logic    w_drain;
    logic    w_out_free;

    logic [CMD_W-1:0] w_cmd;
    t_word            w_val;

    assign w_cmd    = i_s_tdata[CMD_W-1:0];
    assign w_val    = t_word'(i_s_tdata[CMD_W+WORD_W-1:CMD_W]);
    assign w_accept = i_s_tvalid && w_ready;

    assign w_full  = w_used[DEPTH-1];
    assign w_empty = !w_used[0];

    assign w_is_push = (w_cmd == CMD_PUSH_FRONT) || (w_cmd == CMD_PUSH_BACK);
    assign w_is_pop  = (w_cmd == CMD_POP_FRONT)  || (w_cmd == CMD_POP_BACK);
    // logical front maps to cell 0 unless reversed
    assign w_front   = ((w_cmd == CMD_PUSH_FRONT) || (w_cmd == CMD_POP_FRONT)) != r_rev;

    assign w_take_back = w_accept && w_is_pop && !w_empty && !w_front;

    always_comb begin
        w_ctl.shift_r   = w_accept && w_is_push && !w_full && w_front;
        w_ctl.put_back  = w_accept && w_is_push && !w_full && !w_front;
        w_ctl.shift_l   = w_accept && w_is_pop && !w_empty && w_front;
        w_ctl.take_back = w_take_back;
        w_ctl.value     = w_val;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_word w_left_data;
            logic  w_left_used;
            t_word w_right_data;
            logic  w_right_used;

            if (gi == 0) begin : g_head
                assign w_left_data = w_val;
                assign w_left_used = 1'b1;
            end else begin : g_mid
                assign w_left_data = t_word'(w_data[gi-1]);
                assign w_left_used = w_used[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_right_data = '0;
                assign w_right_used = 1'b0;
            end else begin : g_inner
                assign w_right_data = t_word'(w_data[gi+1]);
                assign w_right_used = w_used[gi+1];
            end

            rdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_left_data  (w_left_data),
                .i_left_used  (w_left_used),
                .i_right_data (w_right_data),
                .i_right_used (w_right_used),
                .o_data       (w_data[gi]),
                .o_used       (w_used[gi]),
                .o_last       (w_last[gi])
            );
        end
    endgenerate

    // snapshot taken at the accept edge, before the last cell is released
    rdq_gather u_gather (
        .i_clk  (i_clk),
        .i_load (w_take_back),
        .i_data (w_data),
        .i_last (w_last),
        .o_word (w_gather)
    );

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take_back) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ready       = 1'b0;
        w_gather_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = i_rst_n && !r_skid_valid;
            end
            S_GATHER: begin
                w_gather_done = 1'b1;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (w_cmd == CMD_REVERSE)) begin
                r_rev <= !r_rev;
            end
        end
    end

    // result source for this cycle
    always_comb begin
        w_res_push   = 1'b0;
        w_res_status = STAT_OK;
        w_res_word   = '0;
        if (w_gather_done) begin
            w_res_push = 1'b1;
            w_res_word = w_gather;
        end else if (w_accept && w_is_push && w_full) begin
            w_res_push   = 1'b1;
            w_res_status = STAT_FULL;
        end else if (w_accept && w_is_pop && w_empty) begin
            w_res_push   = 1'b1;
            w_res_status = STAT_EMPTY;
        end else if (w_accept && w_is_pop && w_front) begin
            w_res_push = 1'b1;
            w_res_word = t_word'(w_data[0]);
        end
    end

    // output register with one skid stage behind it
    assign w_drain    = r_out_valid && i_m_tready;
    assign w_out_free = !r_out_valid || w_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_res_push;
            end else begin
                r_out_valid  <= w_res_push;
            end
        end else if (w_res_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_status  <= r_skid_status;
                r_out_word    <= r_skid_word;
                r_skid_status <= w_res_status;
                r_skid_word   <= w_res_word;
            end else begin
                r_out_status <= w_res_status;
                r_out_word   <= w_res_word;
            end
        end else if (w_res_push) begin
            r_skid_status <= w_res_status;
            r_skid_word   <= w_res_word;
        end
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - STAT_W - WORD_W){1'b0}}, r_out_word, r_out_status};

    // a used top cell implies a used cell 0, as the contiguous run from cell 0 requires
    a_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used[DEPTH-1] |-> w_used[0])
        else $error("occupancy run broken");

    // skid holds a word only behind a full output register
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid filled ahead of output");

    // a back pop yields its word when collection ends
    a_back_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_back |=> (r_state == S_GATHER) ##1 r_out_valid)
        else $error("back pop result missing");

endmodule

// File: bench/tb_reversible_deque_top.sv
// Self-checking testbench for reversible_deque_top: directed, fill/overflow and random command streams.
module tb_reversible_deque_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word moving on either side
    localparam int RANDOM_ITEMS   = 900;
    localparam int SEGMENT_ITEMS  = 100;
    localparam int DRAIN_CYCLES   = 16;     // back pop plus output and skid registers
    localparam int MAX_PRINTED    = 40;

    localparam logic [CMD_W-1:0] SPARE_CMDS [3] = '{3'd5, 3'd6, 3'd7};
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef struct {
        t_status status;
        t_word   value;
    } t_deque_reply;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;

    // shadow deque, mirrors the block's contents word for word
    t_word        shadow_store [DEPTH];
    int unsigned  shadow_head  = 0;
    int unsigned  shadow_count = 0;
    bit           shadow_rev   = 1'b0;
    t_deque_reply pending_replies [$];

    int err_count   = 0;
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;

    reversible_deque_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // command[2:0], push_value[34:3]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)      // status[1:0], popped_value[33:2]
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted command to the shadow deque and queues the reply it owes.
    function automatic void track_command(input logic [CMD_W-1:0] cmd, input t_word val);
        t_deque_reply rep;
        bit           at_phys_front;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    rep.status = STAT_FULL;
                    rep.value  = '0;
                    pending_replies = {pending_replies, rep};
                end else begin
                    // reverse flag swaps which physical end is the logical front
                    at_phys_front = (cmd == CMD_PUSH_FRONT) != shadow_rev;
                    if (at_phys_front) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_head] = val;
                    end else begin
                        shadow_store[(shadow_head + shadow_count) % DEPTH] = val;
                    end
                    shadow_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    rep.status = STAT_EMPTY;
                    rep.value  = '0;
                end else begin
                    at_phys_front = (cmd == CMD_POP_FRONT) != shadow_rev;
                    rep.status = STAT_OK;
                    if (at_phys_front) begin
                        rep.value   = shadow_store[shadow_head];
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end else begin
                        rep.value = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
                    end
                    shadow_count--;
                end
                pending_replies = {pending_replies, rep};
            end
            CMD_REVERSE: shadow_rev = !shadow_rev;
            default: ;  // spare codes are dropped by the block
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    // Sends one word; leaves tvalid high so a following word can go back to back.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input t_word val);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - WORD_W){1'b0}}, val, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_command(cmd, val);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Pops on an empty deque, in both orientations, and spare codes that must stay silent.
    task automatic test_empty_queue();
        send_word(CMD_POP_FRONT, WORD_MAX);
        send_word(CMD_POP_BACK, WORD_MIN);
        send_word(CMD_REVERSE, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, -1);
        send_word(CMD_REVERSE, '0);
        foreach (SPARE_CMDS[i]) send_word(SPARE_CMDS[i], -1);
        stop_sending();
    endtask

    // Every command at both ends, extreme values, reversed and normal orientation.
    task automatic test_end_operations();
        send_word(CMD_PUSH_FRONT, WORD_MAX);
        send_word(CMD_PUSH_BACK, WORD_MIN);
        send_word(CMD_PUSH_FRONT, '0);
        send_word(CMD_PUSH_BACK, -1);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_REVERSE, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_PUSH_FRONT, 32'sh5555_5555);
        send_word(CMD_PUSH_BACK, 32'shAAAA_AAAA);
        send_word(SPARE_CMDS[0], 32'sh1234_5678);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_REVERSE, '0);
        stop_sending();
    endtask

    // Fills the store to the brim and pushes into a full deque at both ends;
    // the random mix then starts from a full store.
    task automatic test_fill_and_overflow();
        int n;
        n = 0;
        while (shadow_count < DEPTH) begin
            if (n == DEPTH / 2)
                send_word(CMD_REVERSE, '0);
            send_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom());
            n++;
        end
        send_word(CMD_PUSH_FRONT, WORD_MAX);
        send_word(CMD_PUSH_BACK, WORD_MIN);
        send_word(CMD_REVERSE, '0);
        send_word(CMD_PUSH_BACK, -1);
        send_word(CMD_PUSH_FRONT, '0);
        // one slot frees up, first push fits, second hits the bound again
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_PUSH_BACK, 32'sh0F0F_0F0F);
        send_word(CMD_PUSH_FRONT, 32'shF0F0_F0F0);
        stop_sending();
    endtask

    // Random streams in segments that lean toward pushes, pops or neither.
    task automatic test_random_mix();
        int done_items;
        int push_pct;
        int r;
        logic [CMD_W-1:0] cmd;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 50;
                default: push_pct = 25;
            endcase
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            repeat (SEGMENT_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    cmd = SPARE_CMDS[$urandom_range(0, 2)];
                else if (r < 10)
                    cmd = CMD_REVERSE;
                else if ($urandom_range(0, 99) < push_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                send_word(cmd, $urandom());
                if (r >= 3)
                    done_items++;
            end
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        stop_sending();
    endtask

    // Result side: random back-pressure, each word checked against the oldest owed reply.
    initial begin : result_checker
        int           gap;
        t_deque_reply want;
        t_status      got_status;
        t_word        got_value;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = snk_idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got_status = t_status'(m_tdata[STAT_W-1:0]);
            got_value  = m_tdata[STAT_W +: WORD_W];
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unrequested result status=%0d value=%0d",
                                          got_status, got_value));
            end else begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              got_status, want.status));
                if (got_value !== want.value)
                    report_mismatch($sformatf("popped_value %0d, wanted %0d",
                                              got_value, want.value));
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_reversible_deque_top: done, errors");
        $finish;
    end

    initial begin : main_sequence
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_end_operations();
        test_fill_and_overflow();
        test_random_mix();

        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0) begin
            $display("tb_reversible_deque_top: done, clean");
        end else begin
            $display("tb_reversible_deque_top: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rdq_pkg.sv
rtl/rdq_cell.sv
rtl/rdq_gather.sv
rtl/reversible_deque_top.sv
bench/tb_reversible_deque_top.sv
